// File: design/lgfb_pkg.sv
// shared types, constants and the chain index mapping for the led grayscale frame buffer
`default_nettype none
package lgfb_pkg;

   localparam int MaxChips           = 16;
   localparam int ChannelsPerChip    = 16;
   localparam int BytesPerChip       = 32;
   localparam int PackedBytesPerChip = 8 * 3;
   localparam int ChainStep          = 8 * 3;
   localparam int StoreBytes         = MaxChips * BytesPerChip;
   localparam int AddrW              = $clog2(StoreBytes);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_RGB   = 2'd2,
      OP_SHIFT = 2'd3
   } op_type;

   localparam logic [1:0] CSR_CHIP_COUNT = 2'd0;
   localparam logic [1:0] CSR_TWELVE_BIT = 2'd1;
   localparam logic [1:0] CSR_MAPPING    = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MUL, ST_DSTART, ST_DWAIT, ST_MAP, ST_RD0, ST_RD1,
      ST_RD2, ST_WR1, ST_WR0, ST_SHIFT, ST_SBYTE, ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [4:0]       chips;
      logic             twelve;
      logic             map_on;
      logic [8:0]       chans;
      logic [AddrW-1:0] frame_last;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  idx;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] limit;
      logic        err;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

   // snake chain reordering, channel assumed inside the chain
   function automatic logic [7:0] map_channel(input logic [7:0] ch, input logic [4:0] chips,
                                              input logic map_on);
      logic [4:0] seg;
      logic [4:0] segs;
      logic [4:0] stops;
      logic [4:0] rem;
      logic [9:0] p;
      seg   = 5'((10'(ch[7:3]) * 10'd11) >> 5);
      rem   = 5'(ch - 8'(8'(seg) * 8'(ChainStep)));
      segs  = 5'((10'(chips) * 10'd11) >> 5);
      stops = 5'((segs << 1) - 5'd1);
      if (!map_on) begin
         p = 10'(ch);
      end else if (9'(ch) < 9'(9'(chips) * 9'd8)) begin
         p = 10'(ch) + 10'(10'(seg) * 10'(ChainStep));
      end else if (seg > stops) begin
         p = 10'(ch);
      end else begin
         p = 10'(10'(stops - seg) * 10'(2 * ChainStep)) + 10'(ChainStep) + 10'(rem);
      end
      return p[7:0];
   endfunction

endpackage
`default_nettype wire

// File: design/lgfb_ram.sv
// generic single write port ram with registered read
`default_nettype none
module lgfb_ram #(
   parameter int Width = 8,
   parameter int Depth = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: design/lgfb_div.sv
// restoring divider, one quotient bit per cycle, for the rgb sum limit scaling
`default_nettype none
module lgfb_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [17:0] divisor,
   output logic             done,
   output logic [15:0]      quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [17:0] rem_ff, rem_in;
   logic [17:0] dsr_ff, dsr_in;
   logic [18:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, dvd_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = 18'(shifted - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[17:0];
            dvd_in = {dvd_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[15:0];
endmodule
`default_nettype wire

// File: design/lgfb_front.sv
// front end: accepts requests, flags range errors and queues them for the back end
`default_nettype none
module lgfb_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lgfb_pkg::cfg_type         cfg,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [71:0]              req_tdata,  // channel_index, value_red, value_green, value_blue, sum_limit
   input  wire logic [1:0]               req_tuser,  // operation
   input  wire lgfb_pkg::back_status_type status,
   output lgfb_pkg::queue_head_type       head
);
   import lgfb_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item;
   logic       push;
   logic       pop;

   always_comb begin
      item.op    = op_type'(req_tuser);
      item.idx   = req_tdata[7:0];
      item.red   = req_tdata[23:8];
      item.green = req_tdata[39:24];
      item.blue  = req_tdata[55:40];
      item.limit = req_tdata[71:56];
      unique case (item.op)
         OP_WRITE, OP_READ: item.err = ({1'b0, item.idx} >= cfg.chans);
         OP_RGB:            item.err = (10'(10'(item.idx) * 10'd3) + 10'd2 >= 10'(cfg.chans));
         OP_SHIFT:          item.err = 1'b0;
         default:           item.err = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != 2'd2) && !status.clearing;
   assign push       = req_tvalid && req_tready;
   assign pop        = status.pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];
endmodule
`default_nettype wire

// File: design/lgfb_back.sv
// back end: sequencer over the frame store, rgb scaling and the shift pointer
`default_nettype none
module lgfb_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lgfb_pkg::cfg_type         cfg,
   input  wire logic                     reload,
   input  wire lgfb_pkg::queue_head_type  head,
   output lgfb_pkg::back_status_type      status,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [23:0]                   rsp_tdata,  // read_value, serial_byte
   output logic                          rsp_tlast,
   output logic [0:0]                    rsp_tuser   // index_error
);
   import lgfb_pkg::*;

   back_state_type   state_ff, state_in;
   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;
   item_type         item_ff, item_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [15:0]      val_ff [3];
   logic [15:0]      val_in [3];
   logic [17:0]      sum_ff, sum_in;
   logic [31:0]      prod_ff, prod_in;
   logic [7:0]       p_ff, p_in;
   logic [7:0]       lo_ff, lo_in;
   logic [7:0]       hi_ff, hi_in;
   logic [AddrW-1:0] ptr_ff, ptr_in;
   logic [15:0]      res_value_ff, res_value_in;
   logic [7:0]       res_byte_ff, res_byte_in;
   logic             res_last_ff, res_last_in;
   logic             res_err_ff, res_err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_value_ff, rsp_value_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_err_ff, rsp_err_in;

   logic             wr_en, rd_en, pop, div_start, div_done;
   logic [AddrW-1:0] wr_addr, rd_addr, at, at_next, ptr_eff;
   logic [7:0]       wr_data, rd_data, new_hi, new_lo, ch;
   logic [15:0]      v, div_q, rd_value;
   logic [17:0]      head_sum;

   lgfb_ram #(.Width(8), .Depth(StoreBytes)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgfb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // byte address and packed bytes of the current channel
   always_comb begin
      at      = cfg.twelve ? AddrW'(AddrW'(p_ff) + AddrW'(p_ff[7:1])) : AddrW'({p_ff, 1'b0});
      at_next = AddrW'(at + AddrW'(1));
      v       = cfg.twelve ? {4'd0, val_ff[cnt_ff][11:0]} : val_ff[cnt_ff];
      if (cfg.twelve) begin
         if (p_ff[0]) begin
            new_hi   = v[11:4];
            new_lo   = {v[3:0], lo_ff[3:0]};
            rd_value = {4'd0, rd_data, lo_ff[7:4]};
         end else begin
            new_hi   = {hi_ff[7:4], v[11:8]};
            new_lo   = v[7:0];
            rd_value = {4'd0, rd_data[3:0], lo_ff};
         end
      end else begin
         new_hi   = v[15:8];
         new_lo   = v[7:0];
         rd_value = {rd_data, lo_ff};
      end
      ch       = (item_ff.op == OP_RGB) ?
                 8'(10'(10'(item_ff.idx) * 10'd3) + 10'(cnt_ff)) : item_ff.idx;
      ptr_eff  = (ptr_ff > cfg.frame_last) ? cfg.frame_last : ptr_ff;
      head_sum = 18'(head.item.red) + 18'(head.item.green) + 18'(head.item.blue);
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      p_in         = p_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      res_value_in = res_value_ff;
      res_byte_in  = res_byte_ff;
      res_last_in  = res_last_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      pop          = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (reload) begin
         ptr_in = cfg.frame_last;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = AddrW'(clr_cnt_ff + AddrW'(1));
            if (clr_cnt_ff == AddrW'(StoreBytes - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop          = 1'b1;
               item_in      = head.item;
               cnt_in       = '0;
               val_in[0]    = head.item.red;
               val_in[1]    = head.item.green;
               val_in[2]    = head.item.blue;
               sum_in       = head_sum;
               res_value_in = '0;
               res_byte_in  = '0;
               res_last_in  = 1'b0;
               res_err_in   = head.item.err;
               priority if (head.item.err) begin
                  state_in = ST_DONE;
               end else if (head.item.op == OP_SHIFT) begin
                  state_in = ST_SHIFT;
               end else if (head.item.op == OP_RGB && head.item.limit != 16'd0 &&
                            head_sum > {2'b00, head.item.limit}) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_MAP;
               end
            end
         end
         ST_MUL: begin
            prod_in  = 32'(val_ff[cnt_ff]) * 32'(item_ff.limit);
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               val_in[cnt_ff] = div_q;
               if (cnt_ff == 2'd2) begin
                  cnt_in   = '0;
                  state_in = ST_MAP;
               end else begin
                  cnt_in   = 2'(cnt_ff + 2'd1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MAP: begin
            p_in     = map_channel(ch, cfg.chips, cfg.map_on);
            state_in = ST_RD0;
         end
         ST_RD0: begin
            rd_en    = 1'b1;
            rd_addr  = at;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            rd_en    = 1'b1;
            rd_addr  = at_next;
            lo_in    = rd_data;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            hi_in = rd_data;
            if (item_ff.op == OP_READ) begin
               res_value_in = rd_value;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_WR1;
            end
         end
         ST_WR1: begin
            wr_en    = 1'b1;
            wr_addr  = at_next;
            wr_data  = new_hi;
            state_in = ST_WR0;
         end
         ST_WR0: begin
            wr_en   = 1'b1;
            wr_addr = at;
            wr_data = new_lo;
            if (item_ff.op == OP_RGB && cnt_ff != 2'd2) begin
               cnt_in   = 2'(cnt_ff + 2'd1);
               state_in = ST_MAP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            rd_en   = 1'b1;
            rd_addr = ptr_eff;
            if (ptr_eff == '0) begin
               res_last_in = 1'b1;
               ptr_in      = cfg.frame_last;
            end else begin
               ptr_in = AddrW'(ptr_eff - AddrW'(1));
            end
            state_in = ST_SBYTE;
         end
         ST_SBYTE: begin
            res_byte_in = rd_data;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_byte_in  = res_byte_ff;
               rsp_last_in  = res_last_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ptr_ff       <= AddrW'(BytesPerChip - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      cnt_ff       <= cnt_in;
      val_ff       <= val_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      p_ff         <= p_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      res_value_ff <= res_value_in;
      res_byte_ff  <= res_byte_in;
      res_last_ff  <= res_last_in;
      res_err_ff   <= res_err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.pop      = pop;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {rsp_byte_ff, rsp_value_ff};
   assign rsp_tlast       = rsp_last_ff;
   assign rsp_tuser       = rsp_err_ff;
endmodule
`default_nettype wire

// File: design/led_grayscale_frame_buffer.sv
// Grayscale frame store for a chain of LED driver chips: a 512-byte store holds
// 16-bit or packed 12-bit channel values; requests write or read a channel, write
// an RGB triple scaled down to a sum limit, or shift out the next frame byte from
// the top address down, with rsp_tlast on the byte at address 0. After reset a
// clearing pass zeroes every store byte while req_tready stays low. Requests
// wait in a two-deep queue; one sequencer over the store handles them one at a
// time, and an RGB write over its limit is first scaled per component by a
// multiply and the one-bit-per-cycle divider.
`default_nettype none
module led_grayscale_frame_buffer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // channel_index, value_red, value_green, value_blue, sum_limit
   input  wire logic [1:0]  req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // read_value, serial_byte
   output logic             rsp_tlast,
   output logic [0:0]       rsp_tuser,  // index_error
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [4:0]  csr_wdata
);
   import lgfb_pkg::*;

   logic [4:0]      chip_count_ff, chip_count_in;
   logic            twelve_ff, twelve_in;
   logic            mapping_ff, mapping_in;
   logic            reload_ff, reload_in;
   logic [4:0]      segs;
   logic [9:0]      frame_bytes;
   logic            csr_write;
   cfg_type         cfg;
   queue_head_type  head;
   back_status_type status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      chip_count_in = chip_count_ff;
      twelve_in     = twelve_ff;
      mapping_in    = mapping_ff;
      reload_in     = 1'b0;
      if (csr_write) begin
         unique case (csr_addr)
            CSR_CHIP_COUNT: begin
               chip_count_in = csr_wdata;
               reload_in     = 1'b1;
            end
            CSR_TWELVE_BIT: begin
               twelve_in = csr_wdata[0];
               reload_in = 1'b1;
            end
            CSR_MAPPING: begin
               mapping_in = csr_wdata[0];
               reload_in  = 1'b1;
            end
            default: reload_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_count_ff <= 5'd1;
         twelve_ff     <= 1'b0;
         mapping_ff    <= 1'b0;
         reload_ff     <= 1'b0;
      end else begin
         chip_count_ff <= chip_count_in;
         twelve_ff     <= twelve_in;
         mapping_ff    <= mapping_in;
         reload_ff     <= reload_in;
      end
   end

   always_comb begin
      if (chip_count_ff == 5'd0) begin
         cfg.chips = 5'd1;
      end else if (chip_count_ff > 5'(MaxChips)) begin
         cfg.chips = 5'(MaxChips);
      end else begin
         cfg.chips = chip_count_ff;
      end
      segs           = 5'((10'(cfg.chips) * 10'd11) >> 5);
      cfg.twelve     = twelve_ff;
      cfg.map_on     = mapping_ff && (7'(7'(segs) * 7'd3) == 7'(cfg.chips));
      cfg.chans      = 9'(9'(cfg.chips) * 9'(ChannelsPerChip));
      frame_bytes    = twelve_ff ? 10'(10'(cfg.chips) * 10'(PackedBytesPerChip)) :
                                   10'(10'(cfg.chips) * 10'(BytesPerChip));
      cfg.frame_last = AddrW'(frame_bytes - 10'd1);
   end

   lgfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .head       (head)
   );

   lgfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .reload     (reload_ff),
      .head       (head),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req_tready)
      else $error("request taken during clearing pass");

   a_last_only_on_shift: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[15:0] == 16'd0 && rsp_tuser == 1'b0))
      else $error("latch marker on a non-shift result");

   a_error_has_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 24'd0))
      else $error("error result carries data");
`endif
endmodule
`default_nettype wire

// File: dv/led_grayscale_frame_buffer_tb.sv
// self-checking testbench for the led grayscale frame buffer with a built-in frame store predictor
`default_nettype none
module led_grayscale_frame_buffer_tb;
   import lgfb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      op_type      op;
      logic [7:0]  idx;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] limit;
   } led_req_type;

   typedef struct {
      logic [15:0] read_value;
      logic [7:0]  serial_byte;
      logic        latch_now;
      logic        index_error;
   } led_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_addr = '0;
   logic [4:0]  csr_wdata = '0;

   led_grayscale_frame_buffer u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   led_req_type pending_reqs[$];
   led_rsp_type expected_rsps[$];
   int unsigned send_idle = 29;
   int unsigned recv_idle = 79;
   bit          failed = 0;

   // predictor state
   logic [7:0]  gray_store[StoreBytes];
   int unsigned shift_ptr;
   logic [4:0]  cfg_chips = 5'd1;
   logic        cfg_twelve = 1'b0;
   logic        cfg_map = 1'b0;

   function automatic int unsigned eff_chips();
      if (cfg_chips == 0) return 1;
      if (cfg_chips > MaxChips) return MaxChips;
      return cfg_chips;
   endfunction

   function automatic int unsigned frame_len();
      return eff_chips() * (cfg_twelve ? PackedBytesPerChip : BytesPerChip);
   endfunction

   function automatic int unsigned chan_total();
      return eff_chips() * ChannelsPerChip;
   endfunction

   function automatic logic [7:0] store_rd(int unsigned a);
      return (a < StoreBytes) ? gray_store[a] : 8'h00;
   endfunction

   function automatic void store_wr(int unsigned a, int unsigned v);
      if (a < StoreBytes) gray_store[a] = v[7:0];
   endfunction

   function automatic int unsigned snake_pos(int unsigned ch);
      int unsigned chips, stops, seg;
      chips = eff_chips();
      if (!cfg_map || (chips % 3) != 0) return ch;
      stops = (chips / 3) * 2 - 1;
      seg = ch / ChainStep;
      if (ch < (chan_total() >> 1)) return ch + ChainStep * seg;
      if (seg > stops) return ch;
      return (stops - seg) * (ChainStep * 2) + ChainStep + ch % ChainStep;
   endfunction

   function automatic void put_gray(int unsigned ch, int unsigned v);
      int unsigned p, at;
      p = snake_pos(ch);
      if (cfg_twelve) begin
         at = (p * 3) >> 1;
         v = v & 32'hFFF;
         if (p & 1) begin
            store_wr(at + 1, v >> 4);
            store_wr(at, ((v << 4) & 8'hF0) | (store_rd(at) & 8'h0F));
         end else begin
            store_wr(at + 1, (store_rd(at + 1) & 8'hF0) | (v >> 8));
            store_wr(at, v & 8'hFF);
         end
      end else begin
         store_wr((p << 1) + 1, (v >> 8) & 8'hFF);
         store_wr(p << 1, v & 8'hFF);
      end
   endfunction

   function automatic int unsigned get_gray(int unsigned ch);
      int unsigned p, at;
      p = snake_pos(ch);
      if (cfg_twelve) begin
         at = (p * 3) >> 1;
         if (p & 1) return (int'(store_rd(at + 1)) << 4) | ((store_rd(at) & 8'hF0) >> 4);
         return ((store_rd(at + 1) & 8'h0F) << 8) | store_rd(at);
      end
      return (int'(store_rd((p << 1) + 1)) << 8) | store_rd(p << 1);
   endfunction

   function automatic led_rsp_type predict_frame_op(led_req_type q);
      led_rsp_type o;
      int unsigned chans, base, sum;
      longint unsigned r, g, b, lim;
      o = '{16'h0, 8'h0, 1'b0, 1'b0};
      chans = chan_total();
      r = q.red; g = q.green; b = q.blue; lim = q.limit;
      case (q.op)
         OP_WRITE: begin
            if (q.idx < chans) put_gray(q.idx, r);
            else o.index_error = 1'b1;
         end
         OP_READ: begin
            if (q.idx < chans) o.read_value = 16'(get_gray(q.idx));
            else o.index_error = 1'b1;
         end
         OP_RGB: begin
            base = q.idx * 3;
            if (base + 2 < chans) begin
               sum = r + g + b;
               if (lim != 0 && sum > lim) begin
                  r = (r * lim) / sum;
                  g = (g * lim) / sum;
                  b = (b * lim) / sum;
               end
               put_gray(base, r);
               put_gray(base + 1, g);
               put_gray(base + 2, b);
            end else begin
               o.index_error = 1'b1;
            end
         end
         default: begin
            if (shift_ptr >= frame_len()) shift_ptr = frame_len() - 1;
            o.serial_byte = store_rd(shift_ptr);
            if (shift_ptr == 0) begin
               o.latch_now = 1'b1;
               shift_ptr = frame_len() - 1;
            end else begin
               shift_ptr--;
            end
         end
      endcase
      return o;
   endfunction

   initial begin
      foreach (gray_store[i]) gray_store[i] = 8'h00;
      shift_ptr = BytesPerChip - 1;
   end

   // register transfers update the predictor
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_CHIP_COUNT: begin
               cfg_chips = csr_wdata;
               shift_ptr = frame_len() - 1;
            end
            CSR_TWELVE_BIT: begin
               cfg_twelve = csr_wdata[0];
               shift_ptr = frame_len() - 1;
            end
            CSR_MAPPING: begin
               cfg_map = csr_wdata[0];
               shift_ptr = frame_len() - 1;
            end
            default: ;
         endcase
      end
   end

   // driver
   always @(posedge clock) begin
      led_req_type q;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               q = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= q.op;
               req_tdata  <= {q.limit, q.blue, q.green, q.red, q.idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      led_req_type q;
      led_rsp_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            q.op = op_type'(req_tuser);
            q.idx = req_tdata[7:0];
            q.red = req_tdata[23:8];
            q.green = req_tdata[39:24];
            q.blue = req_tdata[55:40];
            q.limit = req_tdata[71:56];
            expected_rsps.push_back(predict_frame_op(q));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response transfer");
               failed = 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_tdata[15:0] !== e.read_value) begin
                  $error("read_value expected %h actual %h", e.read_value, rsp_tdata[15:0]);
                  failed = 1;
               end
               if (rsp_tdata[23:16] !== e.serial_byte) begin
                  $error("serial_byte expected %h actual %h", e.serial_byte, rsp_tdata[23:16]);
                  failed = 1;
               end
               if (rsp_tlast !== e.latch_now) begin
                  $error("latch_now expected %b actual %b", e.latch_now, rsp_tlast);
                  failed = 1;
               end
               if (rsp_tuser[0] !== e.index_error) begin
                  $error("index_error expected %b actual %b", e.index_error, rsp_tuser[0]);
                  failed = 1;
               end
            end
         end
      end
   end

   task automatic csr_write(logic [1:0] addr, logic [4:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic push_req(op_type op, int unsigned idx, int unsigned r, int unsigned g,
                           int unsigned b, int unsigned lim);
      led_req_type q;
      q.op = op; q.idx = idx[7:0]; q.red = r[15:0]; q.green = g[15:0];
      q.blue = b[15:0]; q.limit = lim[15:0];
      pending_reqs.push_back(q);
   endtask

   function automatic int unsigned rand_value();
      case ($urandom_range(5))
         0: return 0;
         1: return 16'hFFFF;
         2: return $urandom_range(16'h0FFF);
         default: return $urandom_range(16'hFFFF);
      endcase
   endfunction

   task automatic push_random();
      int unsigned chans, idx, lim, kind;
      op_type op;
      chans = chan_total();
      op = op_type'($urandom_range(3));
      kind = $urandom_range(9);
      if (kind == 0) idx = $urandom_range(255);
      else if (op == OP_RGB) idx = $urandom_range(chans / 3);
      else idx = $urandom_range(chans - 1);
      case ($urandom_range(4))
         0, 1: lim = 0;
         2: lim = $urandom_range(1000);
         default: lim = $urandom_range(16'hFFFF);
      endcase
      push_req(op, idx, rand_value(), rand_value(), rand_value(), lim);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      logic [4:0] chip_set[8];
      logic       twelve_set[8];
      logic       map_set[8];
      chip_set   = '{5'd1, 5'd3, 5'd16, 5'd6, 5'd0, 5'd2, 5'd31, 5'd9};
      twelve_set = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
      map_set    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 8; p++) begin
         send_idle = (p < 3) ? 29 : (p < 6) ? 79 : 0;
         recv_idle = (p < 3) ? 79 : (p < 6) ? 29 : 0;
         csr_write(CSR_CHIP_COUNT, chip_set[p]);
         csr_write(CSR_TWELVE_BIT, {4'd0, twelve_set[p]});
         csr_write(CSR_MAPPING, {4'd0, map_set[p]});
         @(posedge clock);
         if (p == 0) begin
            push_req(OP_WRITE, 0, 16'hFFFF, 0, 0, 0);
            push_req(OP_WRITE, 15, 16'hA5C3, 0, 0, 0);
            push_req(OP_READ, 0, 0, 0, 0, 0);
            push_req(OP_READ, 15, 0, 0, 0, 0);
            push_req(OP_WRITE, 16, 16'h1234, 0, 0, 0);
            push_req(OP_READ, 255, 0, 0, 0, 0);
            push_req(OP_RGB, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            push_req(OP_RGB, 1, 300, 200, 100, 600);
            push_req(OP_RGB, 2, 16'h8000, 16'h0001, 16'h7FFF, 0);
            push_req(OP_RGB, 4, 10, 20, 30, 1);
            push_req(OP_RGB, 5, 1, 2, 3, 0);
            push_req(OP_RGB, 255, 1, 2, 3, 0);
            for (int i = 0; i < 6; i++) push_req(OP_READ, i, 0, 0, 0, 0);
            push_req(OP_SHIFT, 0, 0, 0, 0, 0);
         end
         if (p == 1) begin
            push_req(OP_WRITE, 1, 16'hFFFF, 0, 0, 0);
            push_req(OP_WRITE, 2, 16'hFABC, 0, 0, 0);
            push_req(OP_READ, 1, 0, 0, 0, 0);
            push_req(OP_READ, 2, 0, 0, 0, 0);
            push_req(OP_READ, 47, 0, 0, 0, 0);
            push_req(OP_READ, 48, 0, 0, 0, 0);
         end
         if (frame_len() <= 96)
            for (int i = 0; i < frame_len() + 3; i++) push_req(OP_SHIFT, 0, 0, 0, 0, 0);
         for (int i = 0; i < 170; i++) push_random();
         // hold further items until all responses have returned
         wait_drained();
         for (int i = 0; i < 20; i++) push_random();
         wait_drained();
      end
      repeat (50) @(posedge clock);
      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
